[rtl/modinv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_pkg
// Shared types for the modular inverse core: the command group from the
// controller and the status group returned by the datapath.
// ----------------------------------------------------------------------------
package modinv_pkg;

    typedef struct packed {
        logic load;       // capture a new item, seed the coefficients
        logic div_init;   // start a quotient/remainder division
        logic div_step;   // one restoring division bit
        logic update;     // retire a Euclid step
        logic finish;     // form the result registers
    } modinv_cmd_t;

    typedef struct packed {
        logic b_zero;     // divisor of the next step is zero
        logic div_last;   // current division bit is the last one
    } modinv_status_t;

endpackage
`default_nettype wire

[rtl/modular_inverse_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_inverse_core
// Extended Euclidean modular inverse with gcd report.
// ----------------------------------------------------------------------------
// An item is taken when start is high while busy is low. The core runs the
// extended Euclidean algorithm on (modulus, value); each Euclid step is a
// check, one bit-serial restoring division and a coefficient update, and a
// final check ends the item. The number of remainder steps is zero for a
// value of zero and about 92 at most for 63-bit operands. The result appears
// on inverse and gcd with done high for exactly one cycle; the receiver
// cannot stall it, so it must capture the item in that cycle. inverse is
// the modular inverse only when gcd is 1. A new item may be started in the
// cycle done is high.
// ----------------------------------------------------------------------------
module modular_inverse_core #(
    parameter int WIDTH = 63
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [WIDTH-1:0] value,
    input  wire logic [WIDTH-1:0] modulus,
    output logic                  busy,
    output logic                  done,
    output logic [WIDTH-1:0]      inverse,
    output logic [WIDTH-1:0]      gcd
);
    import modinv_pkg::*;

    modinv_cmd_t    cmd;
    modinv_status_t status;

    modinv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    modinv_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk     (clk),
        .cmd     (cmd),
        .status  (status),
        .value   (value),
        .modulus (modulus),
        .inverse (inverse),
        .gcd     (gcd)
    );

endmodule
`default_nettype wire

[rtl/modinv_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_dp
// Datapath: remainder pair, Bezout coefficients, a radix-2 restoring divider
// and a shift-add accumulator that forms coefficient times quotient.
// ----------------------------------------------------------------------------
module modinv_dp #(
    parameter int WIDTH = 63
) (
    input  wire logic                   clk,
    input  wire modinv_pkg::modinv_cmd_t cmd,
    output modinv_pkg::modinv_status_t  status,
    input  wire logic [WIDTH-1:0]       value,
    input  wire logic [WIDTH-1:0]       modulus,
    output logic [WIDTH-1:0]            inverse,
    output logic [WIDTH-1:0]            gcd
);
    import modinv_pkg::*;

    localparam int CW    = WIDTH + 1;
    localparam int CNT_W = $clog2(WIDTH);

    logic [WIDTH-1:0] mod_reg,  mod_next;
    logic [WIDTH-1:0] a_reg,    a_next;
    logic [WIDTH-1:0] b_reg,    b_next;
    logic [WIDTH-1:0] rem_reg,  rem_next;
    logic [WIDTH-1:0] dvd_reg,  dvd_next;
    logic [CW-1:0]    co_reg,   co_next;
    logic [CW-1:0]    cn_reg,   cn_next;
    logic [CW-1:0]    prod_reg, prod_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [WIDTH-1:0] inv_reg,  inv_next;
    logic [WIDTH-1:0] gcd_reg,  gcd_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             q_bit;

    // shift in the next dividend bit and try the subtract
    assign trial = {rem_reg, dvd_reg[WIDTH-1]};
    assign diff  = trial - {1'b0, b_reg};
    assign q_bit = (trial >= {1'b0, b_reg});

    always_comb
    begin
        mod_next  = mod_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        co_next   = co_reg;
        cn_next   = cn_reg;
        prod_next = prod_reg;
        cnt_next  = cnt_reg;
        inv_next  = inv_reg;
        gcd_next  = gcd_reg;

        if (cmd.load)
        begin
            mod_next = modulus;
            a_next   = modulus;
            b_next   = value;
            co_next  = '0;
            cn_next  = CW'(1);
        end
        if (cmd.div_init)
        begin
            rem_next  = '0;
            dvd_next  = a_reg;
            prod_next = '0;
            cnt_next  = '0;
        end
        if (cmd.div_step)
        begin
            rem_next  = q_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            dvd_next  = {dvd_reg[WIDTH-2:0], 1'b0};
            prod_next = {prod_reg[CW-2:0], 1'b0} + (q_bit ? cn_reg : '0);
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        if (cmd.update)
        begin
            a_next  = b_reg;
            b_next  = rem_reg;
            co_next = cn_reg;
            cn_next = co_reg - prod_reg;
        end
        if (cmd.finish)
        begin
            // fold a negative coefficient back into the modulus range once
            inv_next = co_reg[CW-1] ? (co_reg[WIDTH-1:0] + mod_reg) : co_reg[WIDTH-1:0];
            gcd_next = a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mod_reg  <= mod_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        co_reg   <= co_next;
        cn_reg   <= cn_next;
        prod_reg <= prod_next;
        cnt_reg  <= cnt_next;
        inv_reg  <= inv_next;
        gcd_reg  <= gcd_next;
    end

    assign status.b_zero   = (b_reg == '0);
    assign status.div_last = (cnt_reg == CNT_W'(WIDTH - 1));
    assign inverse         = inv_reg;
    assign gcd             = gcd_reg;

endmodule
`default_nettype wire

[rtl/modinv_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modinv_ctrl
// Controller: sequences Euclid steps, each a bit-serial division followed by
// a coefficient update, and raises the done strobe.
// ----------------------------------------------------------------------------
module modinv_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire modinv_pkg::modinv_status_t status,
    output modinv_pkg::modinv_cmd_t        cmd,
    output logic                           busy,
    output logic                           done
);
    import modinv_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg,  done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.b_zero)
                begin
                    cmd.finish = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHECK;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire

[verif/modular_inverse_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_core_tb
// Self-checking bench for the extended Euclidean inverse core. A clocked
// driver issues (value, modulus) items from a queue, a clocked monitor checks
// each one-cycle result against a local Euclid model. The mix is directed
// corner cases first, then random operands of mixed sizes, with random idle
// gaps between items.
// ----------------------------------------------------------------------------
module modular_inverse_core_tb;

    localparam int WIDTH = 63;
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};
    localparam int RANDOM_ITEMS = 80;

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
    } operand_pair_t;

    typedef struct packed {
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] gcd;
    } inverse_result_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic [WIDTH-1:0] value;
    logic [WIDTH-1:0] modulus;
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] gcd;

    operand_pair_t   pending_pairs[$];
    inverse_result_t expected_results[$];
    int unsigned     idle_left;
    int unsigned     items_total;
    int unsigned     results_seen;
    int unsigned     mismatch_count;

    modular_inverse_core #(
        .WIDTH(WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .value(value),
        .modulus(modulus),
        .busy(busy),
        .done(done),
        .inverse(inverse),
        .gcd(gcd)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Euclid on (modulus, value), coefficient kept as 64-bit two's complement
    function automatic inverse_result_t euclid_inverse(input logic [WIDTH-1:0] v,
                                                       input logic [WIDTH-1:0] m);
        logic [63:0] dividend;
        logic [63:0] divisor;
        logic [63:0] coef_prev;
        logic [63:0] coef_cur;
        logic [63:0] quot;
        logic [63:0] rmd;
        logic [63:0] coef_next;
        inverse_result_t res;
        dividend  = 64'(m);
        divisor   = 64'(v);
        coef_prev = 64'd0;
        coef_cur  = 64'd1;
        while (divisor != 64'd0)
        begin
            quot      = dividend / divisor;
            rmd       = dividend % divisor;
            coef_next = coef_prev - coef_cur * quot;
            dividend  = divisor;
            divisor   = rmd;
            coef_prev = coef_cur;
            coef_cur  = coef_next;
        end
        // fold a negative coefficient into the modulus range once
        if (coef_prev[63])
            coef_prev = coef_prev + 64'(m);
        res.inverse = coef_prev[WIDTH-1:0];
        res.gcd     = dividend[WIDTH-1:0];
        return res;
    endfunction

    function automatic logic [WIDTH-1:0] rand_operand();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[WIDTH-1:0];
    endfunction

    // mostly back-to-back or short, now and then a long idle stretch
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 88)
            return $urandom_range(1, 4);
        else
            return $urandom_range(20, 250);
    endfunction

    task automatic queue_pair(input logic [WIDTH-1:0] v, input logic [WIDTH-1:0] m);
        operand_pair_t p;
        p.value   = v;
        p.modulus = m;
        pending_pairs.push_back(p);
        items_total++;
    endtask

    task automatic log_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatch_count++;
    endtask

    // driver: hold an item until taken, then count out the gap while idle
    always @(posedge clk or negedge rst_n)
    begin : driver
        operand_pair_t nxt;
        int unsigned   gap;
        logic          slot_free;
        if (!rst_n)
        begin
            start     <= 1'b0;
            value     <= '0;
            modulus   <= '0;
            idle_left <= 0;
        end
        else
        begin
            gap       = idle_left;
            slot_free = !start;
            if (start && !busy)
            begin
                expected_results.push_back(euclid_inverse(value, modulus));
                gap       = pick_gap();
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (gap == 0 && pending_pairs.size() != 0)
                begin
                    nxt     = pending_pairs.pop_front();
                    start   <= 1'b1;
                    value   <= nxt.value;
                    modulus <= nxt.modulus;
                end
                else
                begin
                    // idle: put junk on the operand lines
                    start   <= 1'b0;
                    value   <= rand_operand();
                    modulus <= rand_operand();
                    if (gap != 0 && !busy)
                        gap = gap - 1;
                end
                idle_left <= gap;
            end
        end
    end

    // monitor: results last one cycle, take them at the edge that ends it
    always @(posedge clk)
    begin : monitor
        inverse_result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                log_mismatch($sformatf("unexpected result inverse=%0d gcd=%0d",
                                       inverse, gcd));
            end
            else
            begin
                want = expected_results.pop_front();
                if (inverse !== want.inverse)
                    log_mismatch($sformatf("inverse got %0d want %0d",
                                           inverse, want.inverse));
                if (gcd !== want.gcd)
                    log_mismatch($sformatf("gcd got %0d want %0d", gcd, want.gcd));
            end
        end
    end

    initial
    begin : stimulus
        logic [63:0]      fib_lo;
        logic [63:0]      fib_hi;
        logic [63:0]      fib_sum;
        logic [WIDTH-1:0] a;
        logic [WIDTH-1:0] b;
        logic [WIDTH-1:0] swap;
        int unsigned      g;
        int unsigned      kind;
        rst_n          = 1'b0;
        items_total    = 0;
        results_seen   = 0;
        mismatch_count = 0;

        fib_lo = 64'd0;
        fib_hi = 64'd1;
        for (int i = 0; i < 91; i++)
        begin
            fib_sum = fib_lo + fib_hi;
            fib_lo  = fib_hi;
            fib_hi  = fib_sum;
        end

        // corner cases: zeros, ones, extremes, swapped order, shared factors
        queue_pair('0, '0);
        queue_pair('0, ALL_ONES);
        queue_pair(WIDTH'(5), '0);
        queue_pair(ALL_ONES, '0);
        queue_pair(WIDTH'(1), WIDTH'(1));
        queue_pair(WIDTH'(1), ALL_ONES);
        queue_pair(ALL_ONES, ALL_ONES);
        queue_pair(ALL_ONES, WIDTH'(1));
        queue_pair(WIDTH'(3), WIDTH'(7));
        queue_pair(WIDTH'(10), WIDTH'(3));
        queue_pair(ALL_ONES, WIDTH'(12345));
        queue_pair(WIDTH'(6), WIDTH'(9));
        queue_pair(WIDTH'(17), WIDTH'(3120));
        queue_pair(WIDTH'(65537), ALL_ONES - WIDTH'(1));
        queue_pair(ALL_ONES - WIDTH'(1), ALL_ONES);
        queue_pair(WIDTH'(2), WIDTH'(1) << (WIDTH - 1));
        queue_pair(WIDTH'(1) << (WIDTH - 1), ALL_ONES);
        queue_pair(WIDTH'({(WIDTH+1)/2{2'b01}}), WIDTH'({(WIDTH+1)/2{2'b10}}));
        // consecutive Fibonacci numbers give the longest Euclid chain
        queue_pair(fib_lo[WIDTH-1:0], fib_hi[WIDTH-1:0]);
        queue_pair(fib_hi[WIDTH-1:0], fib_lo[WIDTH-1:0]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            a    = rand_operand();
            b    = rand_operand();
            if (kind < 40)
            begin
                queue_pair(a, b);
            end
            else if (kind < 65)
            begin
                queue_pair(a >> $urandom_range(0, WIDTH - 1),
                           b >> $urandom_range(0, WIDTH - 1));
            end
            else if (kind < 80)
            begin
                a = a >> $urandom_range(0, 20);
                b = b >> $urandom_range(0, WIDTH - 1);
                if (a < b)
                begin
                    swap = a;
                    a    = b;
                    b    = swap;
                end
                queue_pair(a, b);
            end
            else if (kind < 90)
            begin
                // force a common factor so no inverse exists
                g = $urandom_range(2, 1000);
                queue_pair((a >> $urandom_range(23, WIDTH - 1)) * WIDTH'(g),
                           (b >> $urandom_range(23, WIDTH - 1)) * WIDTH'(g));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: queue_pair('0, b);
                    1: queue_pair(a, '0);
                    2: queue_pair(a, a);
                    default: queue_pair(a, WIDTH'(1));
                endcase
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (results_seen < items_total)
            @(negedge clk);
        repeat (50) @(negedge clk);

        if (expected_results.size() != 0)
            log_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        if (mismatch_count == 0)
        begin
            $display("modular_inverse_core_tb: clean");
        end
        else
        begin
            $display("modular_inverse_core_tb: errors");
        end
        $finish;
    end

    // time limit, several times the slowest legal run
    initial
    begin : watchdog
        #40_000_000;
        $display("modular_inverse_core_tb: errors");
        $finish;
    end

endmodule
